// File: sv/gpcl_pkg.sv
// ----------------------------------------------------------------------------
// gpcl_pkg
// Shared types and constants for the gradient palette color lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gpcl_pkg;

  // Table geometry
  localparam int MAX_STOPS     = 16;
  localparam int IDX_W         = $clog2(MAX_STOPS);
  localparam int COUNT_W       = IDX_W + 1;
  localparam int POS_FRAC_BITS = 16;
  localparam int POS_W         = POS_FRAC_BITS + 1;
  localparam int CH_W          = 8;
  localparam int COLOR_W       = 3 * CH_W;
  localparam int ENTRY_W       = POS_W + COLOR_W;

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

  // Brightness scaling: floor(x / 100) == (x * 5243) >> 19 for x <= 255 * 100
  localparam int BRIGHT_W    = 7;
  localparam int BRIGHT_MAX  = 100;
  localparam int PROD_W      = CH_W + BRIGHT_W;
  localparam int RECIP_W     = 13;
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  // Divider: one quotient bit per cycle, quotient bits POS_FRAC_BITS..0
  localparam int DIV_STEPS = POS_FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Stream payload layout
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = COLOR_W;

  // Request kinds carried in tuser
  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  // Lookup sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_SCAN,
    ST_DIV,
    ST_BLEND,
    ST_SCALE,
    ST_OUT
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: sv/gpcl_div.sv
// ----------------------------------------------------------------------------
// gpcl_div
// Restoring divider, one quotient bit per cycle:
// quotient = floor(dividend * 2^POS_FRAC_BITS / divisor), dividend <= divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module gpcl_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [gpcl_pkg::POS_W-1:0] dividend,
  input  wire logic [gpcl_pkg::POS_W-1:0] divisor,
  output gpcl_pkg::div_status_t          status,
  output logic      [gpcl_pkg::POS_W-1:0] quotient
);
  import gpcl_pkg::*;

  logic [POS_W:0]     rem;
  logic [POS_W-1:0]   dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic               done;

  logic [POS_W:0]     trial;
  logic               fits;

  // First step compares the dividend as is, later steps shift in a zero
  always_comb begin
    if (cnt == DIV_CNT_W'(DIV_STEPS)) begin
      trial = rem;
    end else begin
      trial = {rem[POS_W-1:0], 1'b0};
    end
    fits = (trial >= {1'b0, dvs});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= trial - {1'b0, dvs};
      end else begin
        rem <= trial;
      end
      quotient <= {quotient[POS_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

// File: sv/gradient_palette_color_lookup_unit.sv
// ----------------------------------------------------------------------------
// gradient_palette_color_lookup_unit
// Gradient stop table with piecewise linear color lookup and brightness scale.
// ----------------------------------------------------------------------------
// Load request: accepted while the sequencer is idle, written to the stop memory at accept.
// Lookup request: positions at 0 or at/above 1.0 read one stop directly; others walk
// the stops (one memory read per cycle) to the matching segment, then run the
// 17-step divider unless the segment has zero length, then blend and scale. The
// result is registered in the output register; one lookup is in work at a time.
// Reset: control cleared, stop_count set to 1; the stop memory is undefined.
`default_nettype none

module gradient_palette_color_lookup_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // stop_count write
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gpcl_pkg::COUNT_W-1:0]   cfg_data,
  // Requests
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [3:0] stop_index, [20:4] stop_position, [44:21] stop_color,
  // [61:45] lookup_position, [69:62] brightness, [71:70] zero
  input  wire logic [gpcl_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] action
  input  wire logic                           s_axis_tuser,
  // Results
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic      [gpcl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import gpcl_pkg::*;

  // Request fields
  logic [IDX_W-1:0]   in_index;
  logic [POS_W-1:0]   in_stop_pos;
  logic [COLOR_W-1:0] in_stop_color;
  logic [POS_W-1:0]   in_lookup_pos;
  logic [CH_W-1:0]    in_bright;
  logic               in_accept;
  logic               in_lookup;

  assign in_index      = s_axis_tdata[3:0];
  assign in_stop_pos   = s_axis_tdata[20:4];
  assign in_stop_color = s_axis_tdata[44:21];
  assign in_lookup_pos = s_axis_tdata[61:45];
  assign in_bright     = s_axis_tdata[69:62];
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_lookup     = (action_t'(s_axis_tuser) == ACT_LOOKUP);

  // Stop count register
  logic [COUNT_W-1:0] stop_count;
  logic [IDX_W-1:0]   last_idx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      stop_count <= cfg_data;
    end
  end

  // Index of the last stop in use, count clamped to 1..MAX_STOPS
  always_comb begin
    if (stop_count == '0) begin
      last_idx = '0;
    end else if (stop_count > COUNT_W'(MAX_STOPS)) begin
      last_idx = IDX_W'(MAX_STOPS - 1);
    end else begin
      last_idx = IDX_W'(stop_count - COUNT_W'(1));
    end
  end

  // Sequencer and datapath registers
  state_t             state;
  state_t             state_next;
  logic [POS_W-1:0]   pos_q;
  logic [BRIGHT_W-1:0] bright_q;
  logic               direct_q;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   scan_idx;
  logic [ENTRY_W-1:0] mem_q;
  logic [POS_W-1:0]   prev_pos;
  logic [COLOR_W-1:0] prev_col;
  logic [COLOR_W-1:0] blend_c0;
  logic [COLOR_W-1:0] blend_c1;
  logic [COLOR_W-1:0] col_sel;
  logic [PROD_W-1:0]  prod [3];
  logic               out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  // Stop memory: {position, color}, one write and one registered read port
  logic [ENTRY_W-1:0] stop_mem [MAX_STOPS];
  logic               mem_wr;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      stop_mem[in_index] <= {in_stop_pos, in_stop_color};
    end
    mem_q <= stop_mem[rd_addr];
  end

  // Segment test on the entry just read against the previous one
  logic [POS_W-1:0]   cur_pos;
  logic [COLOR_W-1:0] cur_col;
  logic               seg_hit;
  logic               scan_end;
  logic [POS_W-1:0]   seg_len;
  logic               len_zero;

  assign cur_pos  = mem_q[ENTRY_W-1:COLOR_W];
  assign cur_col  = mem_q[COLOR_W-1:0];
  assign seg_hit  = (scan_idx != '0) && (pos_q >= prev_pos) && (pos_q <= cur_pos);
  assign scan_end = (scan_idx == last_idx);
  assign seg_len  = cur_pos - prev_pos;
  assign len_zero = (seg_len == '0);

  // Divider
  div_status_t      div_st;
  logic [POS_W-1:0] quo;
  logic             div_start;

  gpcl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pos_q - prev_pos),
    .divisor  (seg_len),
    .status   (div_st),
    .quotient (quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && in_lookup) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: state_next = ST_SCAN;
      ST_SCAN: begin
        // a hit on the last segment still interpolates
        if (direct_q) begin
          state_next = ST_SCALE;
        end else if (seg_hit) begin
          state_next = len_zero ? ST_SCALE : ST_DIV;
        end else if (scan_end) begin
          state_next = ST_SCALE;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_BLEND;
        end
      end
      ST_BLEND: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_valid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs
  logic out_load;

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    mem_wr        = (state == ST_IDLE) && s_axis_tvalid && !in_lookup;
    div_start     = (state == ST_SCAN) && !direct_q && seg_hit && !len_zero;
    out_load      = (state == ST_OUT) && (!out_valid || m_axis_tready);
  end

  // One channel of the interpolation: a + trunc((b - a) * frac / ONE)
  function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b,
                                               input logic [POS_W-1:0] frac);
    logic [CH_W-1:0]        diff;
    logic [CH_W+POS_W-1:0]  p;
    logic [CH_W-1:0]        mag;
    diff = (b >= a) ? (b - a) : (a - b);
    p    = (CH_W+POS_W)'(diff) * (CH_W+POS_W)'(frac);
    mag  = p[POS_FRAC_BITS +: CH_W];
    return (b >= a) ? (a + mag) : (a - mag);
  endfunction

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept && in_lookup) begin
          pos_q    <= in_lookup_pos;
          bright_q <= (in_bright > CH_W'(BRIGHT_MAX)) ? BRIGHT_W'(BRIGHT_MAX)
                                                      : in_bright[BRIGHT_W-1:0];
          direct_q <= (in_lookup_pos == '0) || (in_lookup_pos >= POS_ONE);
          rd_addr  <= (in_lookup_pos >= POS_ONE) ? last_idx : '0;
          scan_idx <= '0;
        end
      end
      ST_ISSUE: begin
        rd_addr <= rd_addr + IDX_W'(1);
      end
      ST_SCAN: begin
        rd_addr  <= rd_addr + IDX_W'(1);
        scan_idx <= scan_idx + IDX_W'(1);
        prev_pos <= cur_pos;
        prev_col <= cur_col;
        blend_c0 <= prev_col;
        blend_c1 <= cur_col;
        if (direct_q) begin
          col_sel <= cur_col;
        end else if (seg_hit) begin
          col_sel <= prev_col;
        end else begin
          col_sel <= cur_col;
        end
      end
      ST_BLEND: begin
        col_sel <= {blend_ch(blend_c0[23:16], blend_c1[23:16], quo),
                    blend_ch(blend_c0[15:8],  blend_c1[15:8],  quo),
                    blend_ch(blend_c0[7:0],   blend_c1[7:0],   quo)};
      end
      ST_SCALE: begin
        prod[0] <= PROD_W'(col_sel[23:16]) * PROD_W'(bright_q);
        prod[1] <= PROD_W'(col_sel[15:8])  * PROD_W'(bright_q);
        prod[2] <= PROD_W'(col_sel[7:0])   * PROD_W'(bright_q);
      end
      default: ;
    endcase
  end

  // Divide by 100 through the reciprocal, into the output register
  logic [PROD_W+RECIP_W-1:0] quot100 [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quot100[c] = (PROD_W+RECIP_W)'(prod[c]) * (PROD_W+RECIP_W)'(RECIP_100);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {quot100[2][RECIP_SHIFT +: CH_W],
                   quot100[1][RECIP_SHIFT +: CH_W],
                   quot100[0][RECIP_SHIFT +: CH_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

`ifndef SYNTHESIS
  // Divider runs only while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> (state == ST_DIV))
    else $error("divider busy outside divide state");

  // The walk never examines a stop past the last stop in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_idx <= last_idx))
    else $error("stop walk ran past last stop");

  // The fraction never exceeds 1.0
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLEND) |-> (quo <= POS_ONE))
    else $error("interpolation fraction above 1.0");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the gradient palette color lookup unit against its own predictor.
// Load requests fill a mirror of the stop table and the stop count register
// is tracked at every write; each accepted lookup queues the predicted
// pixel, and every result is compared channel by channel with the oldest
// entry. Directed tests cover single-stop tables, a full ramp, duplicate
// and unsorted stops, count extremes and a long output stall. They are
// followed by random phases with both sides idling.
// ----------------------------------------------------------------------------

module testbench;
  import gpcl_pkg::*;

  localparam int DRAIN_CYCLES   = 64;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT    = 3000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 130;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Request payload, first field in the lowest bits
  typedef struct packed {
    logic [1:0]         pad;
    logic [7:0]         brightness;
    logic [POS_W-1:0]   lookup_pos;
    logic [COLOR_W-1:0] stop_color;
    logic [POS_W-1:0]   stop_pos;
    logic [IDX_W-1:0]   stop_index;
  } stop_req_t;

  // Result payload: red in the lowest byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predictor state, updated at every accepted request
  logic [COUNT_W-1:0]    active_stops;
  logic [POS_W-1:0]      stop_pos_mem [MAX_STOPS];
  logic [COLOR_W-1:0]    stop_rgb_mem [MAX_STOPS];
  pixel_t                pixel_expect_q [$];

  // Stimulus side
  logic [POS_W-1:0]      issued_pos [MAX_STOPS];
  bit                    idle_on;
  bit                    rx_hold_req;
  int                    error_count = 0;

  gradient_palette_color_lookup_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] blend_channel(logic [7:0] near, logic [7:0] far,
                                               longint unsigned frac);
    longint unsigned a;
    longint unsigned b;
    a = near;
    b = far;
    if (b >= a) return 8'(a + (((b - a) * frac) >> POS_FRAC_BITS));
    return 8'(a - (((a - b) * frac) >> POS_FRAC_BITS));
  endfunction

  function automatic pixel_t predict_pixel(logic [POS_W-1:0] lpos, logic [7:0] pct);
    int unsigned        n;
    int unsigned        i;
    int unsigned        scale;
    longint unsigned    p;
    longint unsigned    lo;
    longint unsigned    hi;
    longint unsigned    frac;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] c_a;
    logic [COLOR_W-1:0] c_b;
    bit                 found;
    pixel_t             px;
    n = active_stops;
    if (n == 0) n = 1;
    if (n > MAX_STOPS) n = MAX_STOPS;
    p = lpos;
    found = 1'b0;
    // unmatched positions fall back to the last stop in use
    c = stop_rgb_mem[n-1];
    if (p == 0) begin
      c = stop_rgb_mem[0];
    end else if (p < POS_ONE) begin
      for (i = 0; i + 1 < n; i++) begin
        lo = stop_pos_mem[i];
        hi = stop_pos_mem[i+1];
        if (!found && p >= lo && p <= hi) begin
          found = 1'b1;
          c_a = stop_rgb_mem[i];
          c_b = stop_rgb_mem[i+1];
          if (hi == lo) begin
            c = c_a;
          end else begin
            frac = ((p - lo) << POS_FRAC_BITS) / (hi - lo);
            c = {blend_channel(c_a[23:16], c_b[23:16], frac),
                 blend_channel(c_a[15:8], c_b[15:8], frac),
                 blend_channel(c_a[7:0], c_b[7:0], frac)};
          end
        end
      end
    end
    scale = (pct > 8'd100) ? 100 : pct;
    px.red   = 8'((32'(c[23:16]) * scale) / 100);
    px.green = 8'((32'(c[15:8]) * scale) / 100);
    px.blue  = 8'((32'(c[7:0]) * scale) / 100);
    return px;
  endfunction

  // Track register writes and requests as the block accepts them
  always @(posedge clk) begin
    stop_req_t req;
    if (rst) begin
      active_stops = COUNT_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) active_stops = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        req = s_axis_tdata;
        if (action_t'(s_axis_tuser) == ACT_LOAD) begin
          stop_pos_mem[req.stop_index] = req.stop_pos;
          stop_rgb_mem[req.stop_index] = req.stop_color;
        end else begin
          pixel_expect_q.push_back(predict_pixel(req.lookup_pos, req.brightness));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_error(string msg);
    $display("tb: error at %0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pixel_expect_q.size() == 0) begin
        report_error($sformatf("result %06h with no lookup pending", got));
      end else begin
        want = pixel_expect_q.pop_front();
        if (got.red !== want.red)
          report_error($sformatf("red %02h, expected %02h", got.red, want.red));
        if (got.green !== want.green)
          report_error($sformatf("green %02h, expected %02h", got.green, want.green));
        if (got.blue !== want.blue)
          report_error($sformatf("blue %02h, expected %02h", got.blue, want.blue));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side ready: random stalls, or one long hold when asked
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: too many cycles with no handshake on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Request and register drivers
  // --------------------------------------------------------------------------
  task automatic send_req(action_t act, stop_req_t req);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= req;
    do @(posedge clk); while (!s_axis_tready);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_load(int idx, logic [POS_W-1:0] pos, logic [COLOR_W-1:0] color);
    stop_req_t req;
    req.pad        = 2'b00;
    req.brightness = 8'($urandom);
    req.lookup_pos = POS_W'($urandom);
    req.stop_color = color;
    req.stop_pos   = pos;
    req.stop_index = IDX_W'(idx);
    issued_pos[idx] = pos;
    send_req(ACT_LOAD, req);
  endtask

  task automatic send_lookup(logic [POS_W-1:0] pos, logic [7:0] pct);
    stop_req_t req;
    req.pad        = 2'b00;
    req.brightness = pct;
    req.lookup_pos = pos;
    req.stop_color = COLOR_W'($urandom);
    req.stop_pos   = POS_W'($urandom);
    req.stop_index = IDX_W'($urandom);
    send_req(ACT_LOOKUP, req);
  endtask

  task automatic cfg_write(logic [COUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, let every pending lookup return, then let the unit settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Fill slots 0..n-1, ascending with some duplicates, or fully scrambled
  task automatic load_table(int n, bit scrambled);
    logic [POS_W-1:0] p;
    int unsigned      step;
    int               i;
    p = ($urandom_range(0, 1) == 0) ? '0 : POS_W'($urandom_range(1, 3000));
    for (i = 0; i < n; i++) begin
      if (scrambled) begin
        p = POS_W'($urandom_range(0, 131071));
      end else if (i > 0) begin
        step = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 131072 / n);
        p = (32'(p) + step > 32'(POS_ONE)) ? POS_ONE : POS_W'(32'(p) + step);
      end
      send_load(i, p, COLOR_W'($urandom));
    end
  endtask

  task automatic send_random_load();
    logic [POS_W-1:0] pos;
    if ($urandom_range(0, 1) == 0)
      pos = POS_W'($urandom_range(0, 65536));
    else
      pos = POS_W'($urandom);
    send_load($urandom_range(0, MAX_STOPS - 1), pos, COLOR_W'($urandom));
  endtask

  // Positions weighted toward the ends, past 1.0 and the stops themselves
  task automatic send_random_lookup(int n);
    logic [POS_W-1:0] pos;
    logic [7:0]       pct;
    case ($urandom_range(0, 9))
      0: pos = '0;
      1: pos = POS_ONE;
      2: pos = POS_W'($urandom_range(65537, 131071));
      3, 4: pos = issued_pos[$urandom_range(0, n - 1)] + POS_W'($urandom_range(0, 2)) -
                  POS_W'(1);
      default: pos = POS_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 7))
      0: pct = 8'd0;
      1: pct = 8'd100;
      2: pct = 8'($urandom_range(101, 255));
      default: pct = 8'($urandom_range(0, 100));
    endcase
    send_lookup(pos, pct);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // One stop in use: every lookup returns slot 0, count zero acts as one
  task automatic test_single_stop();
    cfg_write(COUNT_W'(1));
    send_load(0, POS_MAX, 24'hFFFFFF);
    send_lookup('0, 8'd100);
    send_lookup(POS_ONE, 8'd255);
    send_lookup(POS_MAX, 8'd0);
    send_lookup(POS_W'(1234), 8'd50);
    wait_idle();
    cfg_write(COUNT_W'(0));
    send_load(0, '0, 24'h807F01);
    send_lookup(POS_W'(500), 8'd101);
  endtask

  // Full table, evenly spaced from 0 to 1.0, channels rising and falling
  task automatic test_ramp_table();
    int i;
    wait_idle();
    cfg_write(COUNT_W'(MAX_STOPS));
    for (i = 0; i < MAX_STOPS; i++)
      send_load(i, POS_W'((i * 65536) / 15),
                {8'(i * 17), 8'(255 - i * 17), (i % 2 == 1) ? 8'hFF : 8'h00});
    send_lookup(issued_pos[7], 8'd100);
    send_lookup(issued_pos[3] + POS_W'(1456), 8'd100);
    send_lookup(POS_W'(65535), 8'd255);
    send_lookup(POS_ONE, 8'd37);
    send_lookup(POS_W'(1), 8'd100);
  endtask

  // Zero-length segment, unsorted stops with no match, counts above the table
  task automatic test_degenerate_stops();
    wait_idle();
    cfg_write(COUNT_W'(3));
    send_load(0, POS_W'(40000), 24'h112233);
    send_load(1, POS_W'(30000), 24'hA0B0C0);
    send_load(2, POS_W'(30000), 24'h0F1E2D);
    send_lookup(POS_W'(30000), 8'd100);
    send_lookup(POS_W'(10000), 8'd100);
    send_lookup(POS_W'(50000), 8'd90);
    send_lookup(POS_MAX, 8'd100);
    wait_idle();
    cfg_write(COUNT_W'(31));
    send_lookup(POS_W'(65535), 8'd100);
    send_lookup(POS_W'(35000), 8'd100);
    wait_idle();
    cfg_write(COUNT_W'(17));
    send_lookup(POS_W'(20000), 8'd100);
  endtask

  // Long output hold so the unit backs up into its input
  task automatic test_backpressure();
    int i;
    wait_idle();
    idle_on = 1'b0;
    rx_hold_req = 1'b1;
    for (i = 0; i < 20; i++) send_lookup(POS_W'($urandom_range(1, 65535)), 8'd100);
    // sender pauses until every pending lookup has returned
    wait_idle();
    for (i = 0; i < 4; i++) send_random_lookup(MAX_STOPS);
    idle_on = 1'b1;
  endtask

  // Random phases, each with its own stop count and freshly loaded table
  task automatic test_random_phases();
    logic [COUNT_W-1:0] counts [PHASES];
    logic [COUNT_W-1:0] cnt;
    int                 ph;
    int                 k;
    int                 n;
    counts = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd17, 5'd31, 5'd16, 5'd2, 5'd12, 5'd16};
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      // no idling in one phase mid-run, and none at all in the last phase
      idle_on = (ph != 4) && (ph != PHASES - 1);
      cnt = (ph == PHASES - 2) ? COUNT_W'($urandom_range(0, 31)) : counts[ph];
      cfg_write(cnt);
      n = cnt;
      if (n == 0) n = 1;
      if (n > MAX_STOPS) n = MAX_STOPS;
      load_table(n, $urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 6) == 0)
          send_random_load();
        else
          send_random_lookup(n);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    idle_on       = 1'b1;
    rx_hold_req   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_stop();
    test_ramp_table();
    test_degenerate_stops();
    test_backpressure();
    test_random_phases();
    wait_idle();
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
